// ----- rtl/core/hgps_pkg.sv -----
// ----------------------------------------------------------------------------
// hgps_pkg
// Shared constants, types and helpers for the hex grid pixel shader.
// ----------------------------------------------------------------------------
package hgps_pkg;

  // board storage and fixed point format
  localparam int MAX_GRID  = 32;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = MAX_GRID * MAX_GRID;
  localparam int ADDR_W    = $clog2(CELLS);

  // datapath widths
  localparam int PX_W   = 13;                 // centred pixel, signed
  localparam int PR_W   = 29;                 // pixel times Q1.14 angle
  localparam int RX_W   = 30;                 // rotated position
  localparam int PS_W   = RX_W + 25;          // rotated times scale
  localparam int SUM_W  = PS_W + 1;           // scaled plus origin
  localparam int POS_W  = FRAC_BITS + 14;     // clamped position
  localparam int P6_W   = POS_W + 25;         // position times Q.24 constant
  localparam int W7     = POS_W + 2;          // fq, fr, fs
  localparam int QW     = W7 - FRAC_BITS;     // integer cell coordinate
  localparam int XA_W   = FRAC_BITS + 1;      // folded fraction distance
  localparam int M_W    = FRAC_BITS + 3;      // edge metric
  localparam int DP_W   = M_W + 24;           // metric times sqrt3/2
  localparam int D_W    = DP_W - 24;          // edge distance
  localparam int E_W    = D_W + 1;            // shifted edge distance
  localparam int SH     = 30 - FRAC_BITS;
  localparam int OX_W   = 24 + FRAC_BITS;

  localparam longint ONE_FX   = longint'(1) << FRAC_BITS;
  localparam longint HALF_FX  = ONE_FX / 2;
  localparam longint EDGE_FX  = (ONE_FX + 10) / 20;
  localparam longint LIMIT_FX = longint'(4096) << FRAC_BITS;

  localparam logic signed [24:0] INV_SQRT3_Q24  = 25'sd9686330;
  localparam logic signed [24:0] ONE_THIRD_Q24  = 25'sd5592405;
  localparam logic signed [24:0] TWO_THIRDS_Q24 = 25'sd11184811;
  localparam logic [23:0]        HALF_SQRT3_Q24 = 24'd14529495;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SHADE = 1'b1;

  // register indexes
  localparam logic [2:0] REG_COS   = 3'd0;
  localparam logic [2:0] REG_SIN   = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_GRID  = 3'd3;
  localparam logic [2:0] REG_HW    = 3'd4;
  localparam logic [2:0] REG_HH    = 3'd5;
  localparam logic [2:0] REG_OX    = 3'd6;
  localparam logic [2:0] REG_OY    = 3'd7;

  // piece codes
  localparam logic [2:0] PIECE_BLUE   = 3'd1;
  localparam logic [2:0] PIECE_CYAN   = 3'd2;
  localparam logic [2:0] PIECE_RED    = 3'd3;
  localparam logic [2:0] PIECE_ORANGE = 3'd4;

  // item side band that rides along the pipeline
  typedef struct packed {
    logic       cmd;
    logic [4:0] cq;
    logic [4:0] cr;
    logic [2:0] piece;
    logic       cval;
  } side_t;

  // cell table access
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [3:0]        wdata;
  } cmem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned q, input int unsigned r);
    return ADDR_W'(q * MAX_GRID + r);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] lim;
    lim = SUM_W'(LIMIT_FX);
    if (v > lim) return POS_W'(lim);
    if (v < -lim) return POS_W'(-lim);
    return POS_W'(v);
  endfunction

  // round half away from zero to a whole cell, kept in fixed point
  function automatic logic signed [W7-1:0] round_fx(input logic signed [W7-1:0] v);
    logic signed [W7-1:0] t;
    logic signed [W7-1:0] msk;
    msk = {{(W7-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};
    if (!v[W7-1]) begin
      t = v + W7'(HALF_FX);
      return t & msk;
    end
    t = -v + W7'(HALF_FX);
    return -(t & msk);
  endfunction

  function automatic logic [W7-1:0] abs_w7(input logic signed [W7-1:0] v);
    return v[W7-1] ? W7'(-v) : W7'(v);
  endfunction

endpackage

// ----- rtl/core/hex_grid_pixel_shader_top.sv -----
// ----------------------------------------------------------------------------
// hex_grid_pixel_shader_top
// Pixel shader for a rotated pointy-top hexagon board.
// ----------------------------------------------------------------------------
// Ten-stage pipeline that takes one transfer per clock while in_ready is high
// and returns one color for every shade command (cmd 1); load commands
// (cmd 0) write the cell table in stage nine and return nothing. Stalls on the
// output back up stage by stage, and empty stages are filled while a result
// waits. After reset all 1024 entries of the cell table are swept to zero, one
// entry per cycle; in_ready stays low during that sweep while register writes go
// on as usual. Registers sit on an APB-style port at byte address 4*index.
//
// Stage map:
//   1  centre pixel          2  angle products       3  rotation sums
//   4  scale products        5  origin add, clamp    6  Q.24 constant products
//   7  fq/fr/fs, edge folds  8  cube rounding        9  cell select, table read,
//   10 color (output register)                         edge scale product
// ----------------------------------------------------------------------------
module hex_grid_pixel_shader_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [4:0]  in_cell_q,
  input  logic [4:0]  in_cell_r,
  input  logic [2:0]  in_cell_piece,
  input  logic        in_cell_valid,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_color,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FB = hgps_pkg::FRAC_BITS;

  // ---------------- configuration registers ----------------
  logic signed [15:0] cos_r, sin_r;
  logic [23:0]        scale_r, org_x_r, org_y_r;
  logic [5:0]         grid_r;
  logic [11:0]        hw_r, hh_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= 16'sd16384;
      sin_r   <= 16'sd0;
      scale_r <= 24'd65536;
      grid_r  <= 6'd32;
      hw_r    <= 12'd512;
      hh_r    <= 12'd384;
      org_x_r <= '0;
      org_y_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        hgps_pkg::REG_COS:   cos_r   <= pwdata[15:0];
        hgps_pkg::REG_SIN:   sin_r   <= pwdata[15:0];
        hgps_pkg::REG_SCALE: scale_r <= pwdata[23:0];
        hgps_pkg::REG_GRID:  grid_r  <= pwdata[5:0];
        hgps_pkg::REG_HW:    hw_r    <= pwdata[11:0];
        hgps_pkg::REG_HH:    hh_r    <= pwdata[11:0];
        hgps_pkg::REG_OX:    org_x_r <= pwdata[23:0];
        hgps_pkg::REG_OY:    org_y_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      hgps_pkg::REG_COS:   prdata = {16'd0, cos_r};
      hgps_pkg::REG_SIN:   prdata = {16'd0, sin_r};
      hgps_pkg::REG_SCALE: prdata = {8'd0, scale_r};
      hgps_pkg::REG_GRID:  prdata = {26'd0, grid_r};
      hgps_pkg::REG_HW:    prdata = {20'd0, hw_r};
      hgps_pkg::REG_HH:    prdata = {20'd0, hh_r};
      hgps_pkg::REG_OX:    prdata = {8'd0, org_x_r};
      hgps_pkg::REG_OY:    prdata = {8'd0, org_y_r};
      default:             prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  // adv[k]: stage k takes new contents this cycle. Bubbles collapse.
  logic [9:1]  vld_r;
  logic [10:1] adv;
  logic        out_valid_r;
  logic        mem_busy;
  logic        in_xfer;

  hgps_pkg::side_t side_r [1:9];
  hgps_pkg::side_t in_side;

  always_comb begin
    adv[10] = !out_valid_r || out_ready;
    for (int k = 9; k >= 1; k--) adv[k] = !vld_r[k] || adv[k+1];
  end

  assign in_ready = adv[1] && !mem_busy;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[1]) vld_r[1] <= in_xfer;
      for (int k = 2; k <= 9; k++) if (adv[k]) vld_r[k] <= vld_r[k-1];
      if (adv[10]) out_valid_r <= vld_r[9] && (side_r[9].cmd == hgps_pkg::CMD_SHADE);
    end
  end

  assign in_side = '{cmd: in_cmd, cq: in_cell_q, cr: in_cell_r,
                     piece: in_cell_piece, cval: in_cell_valid};

  always_ff @(posedge clk) begin
    if (adv[1]) side_r[1] <= in_side;
    for (int k = 2; k <= 9; k++) if (adv[k]) side_r[k] <= side_r[k-1];
  end

  // ---------------- stage 1: centre ----------------
  logic signed [hgps_pkg::PX_W-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      px_r <= $signed({1'b0, in_pixel_x}) - $signed({1'b0, hw_r});
      py_r <= $signed({1'b0, in_pixel_y}) - $signed({1'b0, hh_r});
    end
  end

  // ---------------- stage 2: angle products ----------------
  logic signed [hgps_pkg::PR_W-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pxc_r <= px_r * cos_r;
      pys_r <= py_r * sin_r;
      pxs_r <= px_r * sin_r;
      pyc_r <= py_r * cos_r;
    end
  end

  // ---------------- stage 3: rotation ----------------
  logic signed [hgps_pkg::RX_W-1:0] rx_r, ry_r;
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      rx_r <= hgps_pkg::RX_W'(pxc_r) - hgps_pkg::RX_W'(pys_r);
      ry_r <= hgps_pkg::RX_W'(pxs_r) + hgps_pkg::RX_W'(pyc_r);
    end
  end

  // ---------------- stage 4: scale ----------------
  logic signed [hgps_pkg::PS_W-1:0] psx_r, psy_r;
  logic signed [24:0]               scale_s;
  assign scale_s = $signed({1'b0, scale_r});
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      psx_r <= rx_r * scale_s;
      psy_r <= ry_r * scale_s;
    end
  end

  // ---------------- stage 5: origin and clamp ----------------
  logic [hgps_pkg::OX_W-1:0]         oxw, oyw;
  logic signed [hgps_pkg::PS_W-1:0]  shx, shy;
  logic signed [hgps_pkg::SUM_W-1:0] sumx, sumy;
  logic signed [hgps_pkg::POS_W-1:0] ux_r, uy_r;

  assign oxw  = {org_x_r, {FB{1'b0}}} >> 16;
  assign oyw  = {org_y_r, {FB{1'b0}}} >> 16;
  assign shx  = psx_r >>> hgps_pkg::SH;
  assign shy  = psy_r >>> hgps_pkg::SH;
  assign sumx = hgps_pkg::SUM_W'(shx) + $signed(hgps_pkg::SUM_W'(oxw));
  assign sumy = hgps_pkg::SUM_W'(shy) + $signed(hgps_pkg::SUM_W'(oyw));

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ux_r <= hgps_pkg::clamp_pos(sumx);
      uy_r <= hgps_pkg::clamp_pos(sumy);
    end
  end

  // ---------------- stage 6: Q.24 constant products ----------------
  logic signed [hgps_pkg::P6_W-1:0] pa_r, pb_r, pc_r;
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      pa_r <= ux_r * hgps_pkg::INV_SQRT3_Q24;
      pb_r <= uy_r * hgps_pkg::ONE_THIRD_Q24;
      pc_r <= uy_r * hgps_pkg::TWO_THIRDS_Q24;
    end
  end

  // ---------------- stage 7: fractional coordinates, edge folds ----------
  logic signed [hgps_pkg::P6_W-1:0] pa_s, pb_s, pc_s;
  logic signed [hgps_pkg::W7-1:0]   fa, fb, fc, fq, ys, xs;
  logic signed [FB+1:0]             xd, yd;
  logic signed [hgps_pkg::W7-1:0]   fq_r, fr_r, fs_r;
  logic [hgps_pkg::XA_W-1:0]        xa_r, ya_r;

  assign pa_s = pa_r >>> 24;
  assign pb_s = pb_r >>> 24;
  assign pc_s = pc_r >>> 24;
  assign fa   = hgps_pkg::W7'(pa_s);
  assign fb   = hgps_pkg::W7'(pb_s);
  assign fc   = hgps_pkg::W7'(pc_s);
  assign fq   = fa - fb;
  assign ys   = fc - hgps_pkg::W7'(hgps_pkg::HALF_FX);
  // odd rows shift half a cell
  assign xs   = ys[FB] ? fa - hgps_pkg::W7'(hgps_pkg::HALF_FX) : fa;
  assign xd   = $signed({2'b00, xs[FB-1:0]}) - (FB+2)'(hgps_pkg::HALF_FX);
  assign yd   = $signed({2'b00, ys[FB-1:0]}) - (FB+2)'(hgps_pkg::HALF_FX);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      fq_r <= fq;
      fr_r <= fc;
      fs_r <= -fq - fc;
      xa_r <= hgps_pkg::XA_W'(xd[FB+1] ? -xd : xd);
      ya_r <= hgps_pkg::XA_W'(yd[FB+1] ? -yd : yd);
    end
  end

  // ---------------- stage 8: cube rounding, edge metric ----------------
  logic signed [hgps_pkg::W7-1:0] rq, rr, rs;
  logic signed [hgps_pkg::W7-1:0] rq_sh, rr_sh, rs_sh;
  logic [hgps_pkg::M_W-1:0]       m1, m2, mm;
  logic signed [hgps_pkg::M_W:0]  om;
  logic [hgps_pkg::W7-1:0]        dq_r, dr_r, ds_r;
  logic signed [hgps_pkg::QW-1:0] q_r, r_r, s_r;
  logic [hgps_pkg::M_W-1:0]       am_r;

  assign rq    = hgps_pkg::round_fx(fq_r);
  assign rr    = hgps_pkg::round_fx(fr_r);
  assign rs    = hgps_pkg::round_fx(fs_r);
  assign rq_sh = rq >>> FB;
  assign rr_sh = rr >>> FB;
  assign rs_sh = rs >>> FB;
  assign m1    = hgps_pkg::M_W'(xa_r) + hgps_pkg::M_W'(ya_r) + hgps_pkg::M_W'(ya_r >> 1);
  assign m2    = hgps_pkg::M_W'({xa_r, 1'b0});
  assign mm    = (m1 > m2) ? m1 : m2;
  assign om    = (hgps_pkg::M_W+1)'(hgps_pkg::ONE_FX) - $signed({1'b0, mm});

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      dq_r <= hgps_pkg::abs_w7(rq - fq_r);
      dr_r <= hgps_pkg::abs_w7(rr - fr_r);
      ds_r <= hgps_pkg::abs_w7(rs - fs_r);
      q_r  <= hgps_pkg::QW'(rq_sh);
      r_r  <= hgps_pkg::QW'(rr_sh);
      s_r  <= hgps_pkg::QW'(rs_sh);
      am_r <= hgps_pkg::M_W'(om[hgps_pkg::M_W] ? -om : om);
    end
  end

  // ---------------- stage 9: cell select, table access ----------------
  logic signed [hgps_pkg::QW-1:0] qs, rsel;
  logic                           onb, ld_ok;
  hgps_pkg::cmem_req_t            mreq;
  logic [3:0]                     entry_r;
  logic                           onb_r;
  logic [hgps_pkg::DP_W-1:0]      dp_r;

  always_comb begin
    qs   = q_r;
    rsel = r_r;
    if (dq_r > dr_r && dq_r > ds_r) qs = -r_r - s_r;
    else if (dr_r > ds_r)           rsel = -q_r - s_r;
  end

  assign onb = !qs[hgps_pkg::QW-1] && !rsel[hgps_pkg::QW-1] &&
               ($unsigned(qs) < hgps_pkg::QW'(grid_r)) &&
               ($unsigned(rsel) < hgps_pkg::QW'(grid_r)) &&
               ($unsigned(qs) < hgps_pkg::QW'(hgps_pkg::MAX_GRID)) &&
               ($unsigned(rsel) < hgps_pkg::QW'(hgps_pkg::MAX_GRID));

  assign ld_ok = (32'(side_r[8].cq) < hgps_pkg::MAX_GRID) &&
                 (32'(side_r[8].cr) < hgps_pkg::MAX_GRID);

  always_comb begin
    mreq.en    = adv[9];
    mreq.we    = vld_r[8] && (side_r[8].cmd == hgps_pkg::CMD_LOAD) && ld_ok;
    mreq.wdata = {side_r[8].cval, side_r[8].piece};
    if (side_r[8].cmd == hgps_pkg::CMD_LOAD)
      mreq.addr = hgps_pkg::cell_addr(32'(side_r[8].cq), 32'(side_r[8].cr));
    else
      mreq.addr = hgps_pkg::cell_addr(32'($unsigned(qs)), 32'($unsigned(rsel)));
  end

  hgps_cell_mem u_cell_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rdata_r (entry_r),
    .busy    (mem_busy)
  );

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      onb_r <= onb;
      dp_r  <= am_r * hgps_pkg::HALF_SQRT3_Q24;
    end
  end

  // ---------------- stage 10: color ----------------
  logic [hgps_pkg::D_W-1:0]       dd;
  logic signed [hgps_pkg::E_W-1:0] ee;
  logic [hgps_pkg::E_W+7:0]        ev;
  logic [7:0]                      vb;
  logic [23:0]                     rgb;
  logic [31:0]                     color_r;

  assign dd = hgps_pkg::D_W'(dp_r >> 24);
  assign ee = $signed({1'b0, dd}) - hgps_pkg::E_W'(hgps_pkg::EDGE_FX);
  assign ev = (hgps_pkg::E_W+8)'($unsigned(ee)) * 8'd255;
  assign vb = ((ev >> FB) > (hgps_pkg::E_W+8)'(255)) ? 8'd255 : ev[FB+7:FB];

  always_comb begin
    if (!onb_r || !entry_r[3] || ee < 0) begin
      rgb = 24'h000000;
    end else if (ee < hgps_pkg::E_W'(hgps_pkg::EDGE_FX)) begin
      rgb = 24'hFFFFFF;
    end else begin
      case (entry_r[2:0])
        hgps_pkg::PIECE_BLUE:   rgb = {vb, vb, 8'hFF};
        hgps_pkg::PIECE_CYAN:   rgb = {vb, 8'hFF, 8'hFF};
        hgps_pkg::PIECE_RED:    rgb = {8'hFF, vb, vb};
        hgps_pkg::PIECE_ORANGE: rgb = {8'hFF, 8'hFF, vb};
        default:                rgb = {vb, vb, vb};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) color_r <= {rgb, 8'hFF};
  end

  assign out_valid = out_valid_r;
  assign out_color = color_r;

  // ---------------- assertions ----------------
  a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_ready) else $error("transfer taken during table sweep");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> vld_r[1]) else $error("accepted item lost at stage 1");

  a_stall_keeps_s9: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[9] && !adv[9]) |=> vld_r[9]) else $error("stalled stage 9 item dropped");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (color_r[7:0] == 8'hFF)) else $error("alpha byte not opaque");

endmodule

// ----- rtl/core/hgps_cell_mem.sv -----
// ----------------------------------------------------------------------------
// hgps_cell_mem
// Cell table: one port, registered read, zero sweep after reset.
// ----------------------------------------------------------------------------
module hgps_cell_mem (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hgps_pkg::cmem_req_t     req,
  output logic [3:0]              rdata_r,
  output logic                    busy
);

  logic [3:0]                   mem [hgps_pkg::CELLS];
  logic [hgps_pkg::ADDR_W-1:0]  clr_cnt_r;
  logic                         clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == hgps_pkg::ADDR_W'(hgps_pkg::CELLS - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 4'd0;
    end else if (req.en && req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.en) rdata_r <= mem[req.addr];
  end

  assign busy = clr_busy_r;

endmodule

// ----- tb/hex_grid_pixel_shader_top_tb.sv -----
// ----------------------------------------------------------------------------
// hex_grid_pixel_shader_top_tb
// Self-checking bench for the hex grid pixel shader.
// ----------------------------------------------------------------------------
// A queue of cell loads and pixel shades feeds a valid/ready driver. Every
// accepted shade is run through a local fixed-point predictor; the resulting
// color is queued and compared with each color transfer on the output side.
// Registers are rewritten between phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
module hex_grid_pixel_shader_top_tb;

  typedef struct packed {
    logic        cmd;
    logic [11:0] x;
    logic [11:0] y;
    logic [4:0]  q;
    logic [4:0]  r;
    logic [2:0]  piece;
    logic        cval;
  } pix_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [11:0] in_pixel_x;
  logic [11:0] in_pixel_y;
  logic [4:0]  in_cell_q;
  logic [4:0]  in_cell_r;
  logic [2:0]  in_cell_piece;
  logic        in_cell_valid;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_color;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hex_grid_pixel_shader_top i_dut (.*);

  // clock: 20 units per period
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the register file and the cell table
  logic signed [15:0] sh_cos;
  logic signed [15:0] sh_sin;
  logic [23:0]        sh_scale;
  logic [5:0]         sh_grid;
  logic [11:0]        sh_hw;
  logic [11:0]        sh_hh;
  logic [23:0]        sh_ox;
  logic [23:0]        sh_oy;
  logic [3:0]         cell_mem [hgps_pkg::CELLS];

  pix_item_t   pending_items [$];
  logic [31:0] expected_colors [$];
  int          mismatches = 0;
  int          in_gap;
  int          out_gap;
  int          hold_left;
  bit          hold_req;
  bit          hold_done;
  bit          no_idle;
  bit          in_taken;

  // ---------------------------------------------------------------- predictor
  // >>> on a signed longint floors, matching the block's truncations
  function automatic longint mul_c24(longint v, longint c);
    return (v * c) >>> 24;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp_l(longint v);
    if (v > hgps_pkg::LIMIT_FX) return hgps_pkg::LIMIT_FX;
    if (v < -hgps_pkg::LIMIT_FX) return -hgps_pkg::LIMIT_FX;
    return v;
  endfunction

  function automatic longint cell_round(longint v);
    longint t;
    if (v >= 0) begin
      t = v + hgps_pkg::HALF_FX;
      return t - (t & (hgps_pkg::ONE_FX - 1));
    end
    t = -v + hgps_pkg::HALF_FX;
    return -(t - (t & (hgps_pkg::ONE_FX - 1)));
  endfunction

  function automatic logic [31:0] pack_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r, g, b, 8'hFF};
  endfunction

  function automatic logic [31:0] shade_color(logic [11:0] x, logic [11:0] y);
    longint px, py, rx, ry, ux, uy;
    longint fq, fr, fs, rq, rr, rs, dq, dr, ds, q, r, s;
    longint xs, ys, xa, ya, m1, m2, m, e;
    logic [3:0] entry;
    logic [7:0] v;
    px = longint'(x) - longint'(sh_hw);
    py = longint'(y) - longint'(sh_hh);
    rx = px * longint'(sh_cos) - py * longint'(sh_sin);
    ry = px * longint'(sh_sin) + py * longint'(sh_cos);
    ux = clamp_l(((rx * longint'(sh_scale)) >>> hgps_pkg::SH) + longint'(sh_ox));
    uy = clamp_l(((ry * longint'(sh_scale)) >>> hgps_pkg::SH) + longint'(sh_oy));

    // axial coordinates, cube rounding
    fq = mul_c24(ux, longint'(hgps_pkg::INV_SQRT3_Q24)) -
         mul_c24(uy, longint'(hgps_pkg::ONE_THIRD_Q24));
    fr = mul_c24(uy, longint'(hgps_pkg::TWO_THIRDS_Q24));
    fs = -fq - fr;
    rq = cell_round(fq);
    rr = cell_round(fr);
    rs = cell_round(fs);
    dq = abs_l(rq - fq);
    dr = abs_l(rr - fr);
    ds = abs_l(rs - fs);
    q = rq >>> hgps_pkg::FRAC_BITS;
    r = rr >>> hgps_pkg::FRAC_BITS;
    s = rs >>> hgps_pkg::FRAC_BITS;
    if (dq > dr && dq > ds) q = -r - s;
    else if (dr > ds) r = -q - s;

    if (q < 0 || r < 0 || q >= longint'(sh_grid) || r >= longint'(sh_grid) ||
        q >= hgps_pkg::MAX_GRID || r >= hgps_pkg::MAX_GRID)
      return pack_rgb(8'd0, 8'd0, 8'd0);
    entry = cell_mem[q * hgps_pkg::MAX_GRID + r];
    if (!entry[3]) return pack_rgb(8'd0, 8'd0, 8'd0);

    // distance to the hexagon edge
    xs = mul_c24(ux, longint'(hgps_pkg::INV_SQRT3_Q24));
    ys = mul_c24(uy, longint'(hgps_pkg::TWO_THIRDS_Q24)) - hgps_pkg::HALF_FX;
    if (ys[hgps_pkg::FRAC_BITS]) xs = xs - hgps_pkg::HALF_FX;
    xa = abs_l((xs & (hgps_pkg::ONE_FX - 1)) - hgps_pkg::HALF_FX);
    ya = abs_l((ys & (hgps_pkg::ONE_FX - 1)) - hgps_pkg::HALF_FX);
    m1 = xa + ya + (ya >>> 1);
    m2 = xa * 2;
    m  = m1 > m2 ? m1 : m2;
    e  = mul_c24(abs_l(hgps_pkg::ONE_FX - m), longint'(hgps_pkg::HALF_SQRT3_Q24)) -
         hgps_pkg::EDGE_FX;

    if (e < 0) return pack_rgb(8'd0, 8'd0, 8'd0);
    if (e < hgps_pkg::EDGE_FX) return pack_rgb(8'hFF, 8'hFF, 8'hFF);
    e = (e * 255) >>> hgps_pkg::FRAC_BITS;
    v = e > 255 ? 8'hFF : 8'(e);
    case (entry[2:0])
      hgps_pkg::PIECE_BLUE:   return pack_rgb(v, v, 8'hFF);
      hgps_pkg::PIECE_CYAN:   return pack_rgb(v, 8'hFF, 8'hFF);
      hgps_pkg::PIECE_RED:    return pack_rgb(8'hFF, v, v);
      hgps_pkg::PIECE_ORANGE: return pack_rgb(8'hFF, 8'hFF, v);
      default:                return pack_rgb(v, v, v);
    endcase
  endfunction

  // ---------------------------------------------------------- input driver
  always @(posedge clk) begin
    in_taken = in_valid && in_ready;
    if (!rst_n) begin
      foreach (cell_mem[i]) cell_mem[i] = '0;
    end else if (in_taken) begin
      if (in_cmd == hgps_pkg::CMD_LOAD)
        cell_mem[{in_cell_q, in_cell_r}] = {in_cell_valid, in_cell_piece};
      else
        expected_colors.push_back(shade_color(in_pixel_x, in_pixel_y));
    end
  end

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 2);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_cmd        <= hgps_pkg::CMD_LOAD;
      in_pixel_x    <= '0;
      in_pixel_y    <= '0;
      in_cell_q     <= '0;
      in_cell_r     <= '0;
      in_cell_piece <= '0;
      in_cell_valid <= 1'b0;
      in_gap   = 0;
    end else if (!in_valid || in_taken) begin
      // previous transfer done (or nothing on the bus): idle or offer next
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        pix_item_t it;
        it = pending_items.pop_front();
        in_valid      <= 1'b1;
        in_cmd        <= it.cmd;
        in_pixel_x    <= it.x;
        in_pixel_y    <= it.y;
        in_cell_q     <= it.q;
        in_cell_r     <= it.r;
        in_cell_piece <= it.piece;
        in_cell_valid <= it.cval;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------- output side
  // long hold-off when requested: the pipeline fills and in_ready drops
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color transfer %h", out_color);
      end else begin
        logic [31:0] exp_c;
        exp_c = expected_colors.pop_front();
        if (exp_c !== out_color) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected %h, got %h", exp_c, out_color);
        end
      end
    end
  end

  // ---------------------------------------------------------- config port
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hgps_pkg::REG_COS:   sh_cos   = val[15:0];
      hgps_pkg::REG_SIN:   sh_sin   = val[15:0];
      hgps_pkg::REG_SCALE: sh_scale = val[23:0];
      hgps_pkg::REG_GRID:  sh_grid  = val[5:0];
      hgps_pkg::REG_HW:    sh_hw    = val[11:0];
      hgps_pkg::REG_HH:    sh_hh    = val[11:0];
      hgps_pkg::REG_OX:    sh_ox    = val[23:0];
      default:             sh_oy    = val[23:0];
    endcase
  endtask

  // pipeline is ten deep; a trailing load may still be in flight
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_colors.size() > 0)
      @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  function automatic pix_item_t make_load(int q, int r, int piece, int cv);
    pix_item_t it;
    it = '0;
    it.cmd = hgps_pkg::CMD_LOAD;
    it.x = 12'($urandom);
    it.y = 12'($urandom);
    it.q = 5'(q);
    it.r = 5'(r);
    it.piece = 3'(piece);
    it.cval = 1'(cv);
    return it;
  endfunction

  function automatic pix_item_t make_shade(int x, int y);
    pix_item_t it;
    it = '0;
    it.cmd = hgps_pkg::CMD_SHADE;
    it.x = 12'(x);
    it.y = 12'(y);
    it.q = 5'($urandom);
    it.r = 5'($urandom);
    it.piece = 3'($urandom);
    it.cval = 1'($urandom);
    return it;
  endfunction

  // pixel near the image centre, scaled so the board covers the window
  function automatic int near_pix(int ctr, int span);
    int v;
    v = ctr - span + int'($urandom_range(0, 2 * span));
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  // ---------------------------------------------------------- main sequence
  initial begin
    logic [31:0] cv [8];
    int span;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    sh_cos = 16'sd16384; sh_sin = 16'sd0; sh_scale = 24'd65536; sh_grid = 6'd32;
    sh_hw = 12'd512; sh_hh = 12'd384; sh_ox = '0; sh_oy = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corner cells, every piece code, field extremes, reset scale
    pending_items.push_back(make_shade(512, 384));       // empty table: black
    for (int p = 0; p < 8; p++)
      pending_items.push_back(make_load(p, p, p, 1));
    pending_items.push_back(make_load(31, 31, 7, 1));
    pending_items.push_back(make_load(0, 31, 3, 0));     // invalid cell
    pending_items.push_back(make_load(31, 0, 4, 1));
    pending_items.push_back(make_shade(512, 384));
    pending_items.push_back(make_shade(0, 0));
    pending_items.push_back(make_shade(4095, 4095));
    pending_items.push_back(make_shade(4095, 0));
    pending_items.push_back(make_shade(0, 4095));
    for (int p = 1; p < 8; p++)
      pending_items.push_back(make_shade(512 + 2 * p + 1, 384 + 2 * p));
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      // base setting, then one extreme in each of phases 1 to 11; random angle and grid after
      cv[hgps_pkg::REG_COS]   = 32'(16384);
      cv[hgps_pkg::REG_SIN]   = 32'(0);
      cv[hgps_pkg::REG_SCALE] = $urandom_range(2000, 20000);
      cv[hgps_pkg::REG_GRID]  = 32;
      cv[hgps_pkg::REG_HW]    = $urandom_range(0, 2048);
      cv[hgps_pkg::REG_HH]    = $urandom_range(0, 2048);
      cv[hgps_pkg::REG_OX]    = $urandom_range(0, 24'h0C0000);
      cv[hgps_pkg::REG_OY]    = $urandom_range(0, 24'h0C0000);
      case (ph)
        1: cv[hgps_pkg::REG_COS] = 32'(-16384);
        2: begin
          cv[hgps_pkg::REG_COS] = 0;
          cv[hgps_pkg::REG_SIN] = 32'(16384);
        end
        3: begin
          cv[hgps_pkg::REG_COS] = 0;
          cv[hgps_pkg::REG_SIN] = 32'(-16384);
          hold_req = 1'b1;
        end
        4: cv[hgps_pkg::REG_SCALE] = 0;
        5: cv[hgps_pkg::REG_SCALE] = 24'hFFFFFF;        // far positions saturate
        6: cv[hgps_pkg::REG_GRID] = 0;                  // every pixel black
        7: cv[hgps_pkg::REG_GRID] = 1;
        8: cv[hgps_pkg::REG_GRID] = 63;                 // beyond storage
        9: begin
          cv[hgps_pkg::REG_HW] = 0;
          cv[hgps_pkg::REG_HH] = 0;
        end
        10: begin
          cv[hgps_pkg::REG_HW] = 2048;
          cv[hgps_pkg::REG_HH] = 2048;
        end
        11: begin
          cv[hgps_pkg::REG_OX] = 24'hFFFFFF;
          cv[hgps_pkg::REG_OY] = 24'hFFFFFF;
        end
        12, 13, 14, 15: begin
          cv[hgps_pkg::REG_COS] = 32'($urandom_range(0, 32768) - 16384);
          cv[hgps_pkg::REG_SIN] = 32'($urandom_range(0, 32768) - 16384);
          cv[hgps_pkg::REG_GRID] = $urandom_range(1, 32);
        end
        default: ;
      endcase
      for (int i = 0; i < 8; i++) reg_write(3'(i), cv[i]);
      no_idle = (ph % 4 == 2);

      span = cv[hgps_pkg::REG_SCALE][23:0] == 0 ? 2047 :
             (40 << 16) / cv[hgps_pkg::REG_SCALE][23:0];
      if (span > 2047) span = 2047;
      if (span < 4) span = 4;
      for (int k = 0; k < 120; k++) begin
        if (k < 30 || $urandom_range(0, 4) == 0)
          pending_items.push_back(make_load($urandom_range(0, k < 30 ? 15 : 31),
            $urandom_range(0, k < 30 ? 15 : 31), $urandom_range(0, 7),
            $urandom_range(0, 4) != 0));
        else if ($urandom_range(0, 9) == 0)
          pending_items.push_back(make_shade($urandom_range(0, 4095),
                                             $urandom_range(0, 4095)));
        else
          pending_items.push_back(make_shade(near_pix(cv[hgps_pkg::REG_HW], span),
                                             near_pix(cv[hgps_pkg::REG_HH], span)));
      end
      // sender pauses here until every color has come back
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_colors.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
